>>> sv/drdf_pkg.sv
// Shared types and constants for the detection row decode filter.
// Used by drdf_box_scale and detection_row_decode_filter; depends on nothing.

package drdf_pkg;

	localparam int unsigned MAX_CLASSES_DEFAULT = 256;
	localparam int unsigned BOX_VALUES = 5;

	localparam int unsigned VALUE_W = 20;
	localparam int unsigned SCALE_W = 16;
	localparam int unsigned CLASS_W = 8;
	localparam int unsigned COUNT_W = 9;
	localparam int unsigned EDGE_MAG_W = VALUE_W + 1;
	localparam int unsigned EDGE_PROD_W = EDGE_MAG_W + SCALE_W;
	localparam int unsigned SIZE_PROD_W = VALUE_W + SCALE_W;
	localparam int unsigned ADDR_W = 5;
	localparam int unsigned DATA_W = 32;

	localparam logic [COUNT_W-1:0] CLASS_COUNT_RESET = 9'd1;
	localparam logic [VALUE_W-1:0] CONF_THRESH_RESET = 20'd410;
	localparam logic [VALUE_W-1:0] SCORE_THRESH_RESET = 20'd512;
	localparam logic [SCALE_W-1:0] X_SCALE_RESET = 16'd1024;
	localparam logic [SCALE_W-1:0] Y_SCALE_RESET = 16'd1024;

	typedef enum logic [2:0] {
		REG_CLASS_COUNT = 3'd0,
		REG_CONF_THRESH = 3'd1,
		REG_SCORE_THRESH = 3'd2,
		REG_X_SCALE = 3'd3,
		REG_Y_SCALE = 3'd4
	} reg_index_t;

	// One accepted detection before scaling: edge numerators are 2*centre - size.
	typedef struct packed {
		logic [CLASS_W-1:0] class_index;
		logic [VALUE_W-1:0] objectness;
		logic left_neg;
		logic [EDGE_MAG_W-1:0] left_mag;
		logic top_neg;
		logic [EDGE_MAG_W-1:0] top_mag;
		logic [VALUE_W-1:0] width;
		logic [VALUE_W-1:0] height;
		logic [SCALE_W-1:0] x_scale;
		logic [SCALE_W-1:0] y_scale;
	} box_prep_t;

endpackage

>>> sv/detection_row_decode_filter.sv
// Top level of the detection row decode filter: register file, row tracking and filtering.
// Depends on drdf_pkg and drdf_box_scale.
//
//   Port group     Direction  Handshake           Beat
//   in_*           input      in_valid/in_stall   one tensor value
//   out_*          output     out_valid/out_stall one detection at the end of a passing row
//   APB            slave      psel/penable        one register write or read
//
// One tensor value is accepted every cycle while the output is not stalled.
// After the last value of its row is accepted, a detection passes the row filter into the scale
// stage, the scale multipliers into the product register, and saturation into the output register.
// Reset clears the row position, the running best score and the registers to defaults.
// An output stall holds the scale stages; once all three hold detections while the input
// register holds a beat, in_stall rises in the same cycle and the register keeps that beat.

module detection_row_decode_filter #(
	parameter int unsigned MAX_CLASSES = drdf_pkg::MAX_CLASSES_DEFAULT
) (
	input  logic clk,
	input  logic arst_n,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [drdf_pkg::ADDR_W-1:0] paddr,
	input  logic [drdf_pkg::DATA_W-1:0] pwdata,
	output logic [drdf_pkg::DATA_W-1:0] prdata,
	output logic pready,
	input  logic in_valid,
	output logic in_stall,
	input  logic [drdf_pkg::VALUE_W-1:0] tensor_value,
	output logic out_valid,
	input  logic out_stall,
	output logic [drdf_pkg::CLASS_W-1:0] class_index,
	output logic [drdf_pkg::VALUE_W-1:0] objectness,
	output logic signed [15:0] box_left,
	output logic signed [15:0] box_top,
	output logic [14:0] box_width,
	output logic [14:0] box_height
);

	localparam logic [drdf_pkg::COUNT_W-1:0] MaxCls = drdf_pkg::COUNT_W'(MAX_CLASSES);
	localparam logic [drdf_pkg::COUNT_W-1:0] BoxCnt = drdf_pkg::COUNT_W'(drdf_pkg::BOX_VALUES);

	logic [drdf_pkg::COUNT_W-1:0] class_count_q;
	logic [drdf_pkg::VALUE_W-1:0] conf_thresh_q;
	logic [drdf_pkg::VALUE_W-1:0] score_thresh_q;
	logic [drdf_pkg::SCALE_W-1:0] x_scale_q;
	logic [drdf_pkg::SCALE_W-1:0] y_scale_q;

	logic valid_s1;
	logic [drdf_pkg::VALUE_W-1:0] value_s1;

	logic [drdf_pkg::COUNT_W-1:0] pos_q;
	logic [drdf_pkg::VALUE_W-1:0] box_q [drdf_pkg::BOX_VALUES];
	logic [drdf_pkg::VALUE_W-1:0] best_score_q;
	logic [drdf_pkg::CLASS_W-1:0] best_class_q;

	drdf_pkg::reg_index_t reg_sel;
	logic cfg_write;
	logic prep_ready;
	logic advance_s1;
	logic [drdf_pkg::COUNT_W-1:0] eff_classes;
	logic [drdf_pkg::COUNT_W-1:0] last_pos;
	logic is_box;
	logic row_end;
	logic take_best;
	logic [drdf_pkg::VALUE_W-1:0] next_score;
	logic [drdf_pkg::CLASS_W-1:0] next_class;
	logic emit;
	logic signed [drdf_pkg::VALUE_W+1:0] left_num;
	logic signed [drdf_pkg::VALUE_W+1:0] top_num;
	drdf_pkg::box_prep_t prep;

	assign reg_sel = drdf_pkg::reg_index_t'(paddr[4:2]);
	assign cfg_write = psel && penable && pwrite;
	assign pready = 1'b1;

	always_comb begin
		unique case (reg_sel)
			drdf_pkg::REG_CLASS_COUNT: prdata = 32'(class_count_q);
			drdf_pkg::REG_CONF_THRESH: prdata = 32'(conf_thresh_q);
			drdf_pkg::REG_SCORE_THRESH: prdata = 32'(score_thresh_q);
			drdf_pkg::REG_X_SCALE: prdata = 32'(x_scale_q);
			drdf_pkg::REG_Y_SCALE: prdata = 32'(y_scale_q);
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_count_q <= drdf_pkg::CLASS_COUNT_RESET;
			conf_thresh_q <= drdf_pkg::CONF_THRESH_RESET;
			score_thresh_q <= drdf_pkg::SCORE_THRESH_RESET;
			x_scale_q <= drdf_pkg::X_SCALE_RESET;
			y_scale_q <= drdf_pkg::Y_SCALE_RESET;
		end else if (cfg_write) begin
			unique case (reg_sel)
				drdf_pkg::REG_CLASS_COUNT: class_count_q <= pwdata[drdf_pkg::COUNT_W-1:0];
				drdf_pkg::REG_CONF_THRESH: conf_thresh_q <= pwdata[drdf_pkg::VALUE_W-1:0];
				drdf_pkg::REG_SCORE_THRESH: score_thresh_q <= pwdata[drdf_pkg::VALUE_W-1:0];
				drdf_pkg::REG_X_SCALE: x_scale_q <= pwdata[drdf_pkg::SCALE_W-1:0];
				drdf_pkg::REG_Y_SCALE: y_scale_q <= pwdata[drdf_pkg::SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	assign advance_s1 = valid_s1 && prep_ready;
	assign in_stall = valid_s1 && !prep_ready;

	always_comb begin
		if (class_count_q == '0) begin
			eff_classes = drdf_pkg::COUNT_W'(1);
		end else if (class_count_q > MaxCls) begin
			eff_classes = MaxCls;
		end else begin
			eff_classes = class_count_q;
		end
	end

	assign last_pos = BoxCnt - drdf_pkg::COUNT_W'(1) + eff_classes;
	assign is_box = pos_q < BoxCnt;
	assign row_end = pos_q >= last_pos;
	assign take_best = (pos_q == BoxCnt) || (value_s1 > best_score_q);
	assign next_score = take_best ? value_s1 : best_score_q;
	assign next_class = take_best ? drdf_pkg::CLASS_W'(pos_q - BoxCnt) : best_class_q;
	assign emit = row_end && !is_box && (box_q[4] >= conf_thresh_q)
		&& (next_score > score_thresh_q);

	assign left_num = $signed({1'b0, box_q[0], 1'b0}) - $signed({2'b00, box_q[2]});
	assign top_num = $signed({1'b0, box_q[1], 1'b0}) - $signed({2'b00, box_q[3]});

	always_comb begin
		prep.class_index = next_class;
		prep.objectness = box_q[4];
		prep.left_neg = left_num[drdf_pkg::VALUE_W+1];
		prep.left_mag = left_num[drdf_pkg::VALUE_W+1]
			? drdf_pkg::EDGE_MAG_W'(-left_num) : left_num[drdf_pkg::EDGE_MAG_W-1:0];
		prep.top_neg = top_num[drdf_pkg::VALUE_W+1];
		prep.top_mag = top_num[drdf_pkg::VALUE_W+1]
			? drdf_pkg::EDGE_MAG_W'(-top_num) : top_num[drdf_pkg::EDGE_MAG_W-1:0];
		prep.width = box_q[2];
		prep.height = box_q[3];
		prep.x_scale = x_scale_q;
		prep.y_scale = y_scale_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			pos_q <= '0;
			best_score_q <= '0;
			best_class_q <= '0;
		end else begin
			if (!in_stall) begin
				valid_s1 <= in_valid;
			end
			if (advance_s1) begin
				if (!is_box) begin
					best_score_q <= next_score;
					best_class_q <= next_class;
				end
				pos_q <= row_end ? '0 : pos_q + drdf_pkg::COUNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			value_s1 <= tensor_value;
		end
		if (advance_s1 && is_box) begin
			box_q[pos_q[2:0]] <= value_s1;
		end
	end

	drdf_box_scale u_scale (
		.clk(clk),
		.arst_n(arst_n),
		.prep_valid(advance_s1 && emit),
		.prep_ready(prep_ready),
		.prep(prep),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.class_index(class_index),
		.objectness(objectness),
		.box_left(box_left),
		.box_top(box_top),
		.box_width(box_width),
		.box_height(box_height)
	);

endmodule

>>> sv/drdf_box_scale.sv
// Scaling pipeline: box values times image scales, truncation and saturation.
// Depends on drdf_pkg.

module drdf_box_scale (
	input  logic clk,
	input  logic arst_n,
	input  logic prep_valid,
	output logic prep_ready,
	input  drdf_pkg::box_prep_t prep,
	output logic out_valid,
	input  logic out_stall,
	output logic [drdf_pkg::CLASS_W-1:0] class_index,
	output logic [drdf_pkg::VALUE_W-1:0] objectness,
	output logic signed [15:0] box_left,
	output logic signed [15:0] box_top,
	output logic [14:0] box_width,
	output logic [14:0] box_height
);

	logic valid_s2;
	logic valid_s3;
	logic out_valid_q;
	logic out_free;
	logic s3_free;
	logic s2_free;

	drdf_pkg::box_prep_t prep_s2;

	logic [drdf_pkg::CLASS_W-1:0] class_s3;
	logic [drdf_pkg::VALUE_W-1:0] obj_s3;
	logic left_neg_s3;
	logic top_neg_s3;
	logic [drdf_pkg::EDGE_PROD_W-1:0] left_prod_s3;
	logic [drdf_pkg::EDGE_PROD_W-1:0] top_prod_s3;
	logic [drdf_pkg::SIZE_PROD_W-1:0] width_prod_s3;
	logic [drdf_pkg::SIZE_PROD_W-1:0] height_prod_s3;

	logic [15:0] left_px;
	logic [15:0] top_px;
	logic [15:0] width_px;
	logic [15:0] height_px;
	logic [15:0] left_sat;
	logic [15:0] top_sat;
	logic [14:0] width_sat;
	logic [14:0] height_sat;

	logic [drdf_pkg::CLASS_W-1:0] class_q;
	logic [drdf_pkg::VALUE_W-1:0] obj_q;
	logic [15:0] left_q;
	logic [15:0] top_q;
	logic [14:0] width_q;
	logic [14:0] height_q;

	assign out_free = !out_valid_q || !out_stall;
	assign s3_free = !valid_s3 || out_free;
	assign s2_free = !valid_s2 || s3_free;
	assign prep_ready = s2_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s2_free) begin
				valid_s2 <= prep_valid;
			end
			if (s3_free) begin
				valid_s3 <= valid_s2;
			end
			if (out_free) begin
				out_valid_q <= valid_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && prep_valid) begin
			prep_s2 <= prep;
		end
		if (s3_free && valid_s2) begin
			class_s3 <= prep_s2.class_index;
			obj_s3 <= prep_s2.objectness;
			left_neg_s3 <= prep_s2.left_neg;
			top_neg_s3 <= prep_s2.top_neg;
			left_prod_s3 <= prep_s2.left_mag * prep_s2.x_scale;
			top_prod_s3 <= prep_s2.top_mag * prep_s2.y_scale;
			width_prod_s3 <= prep_s2.width * prep_s2.x_scale;
			height_prod_s3 <= prep_s2.height * prep_s2.y_scale;
		end
		if (out_free && valid_s3) begin
			class_q <= class_s3;
			obj_q <= obj_s3;
			left_q <= left_sat;
			top_q <= top_sat;
			width_q <= width_sat;
			height_q <= height_sat;
		end
	end

	// Edge products carry 21 fraction bits, size products 20.
	assign left_px = left_prod_s3[drdf_pkg::EDGE_PROD_W-1 -: 16];
	assign top_px = top_prod_s3[drdf_pkg::EDGE_PROD_W-1 -: 16];
	assign width_px = width_prod_s3[drdf_pkg::SIZE_PROD_W-1 -: 16];
	assign height_px = height_prod_s3[drdf_pkg::SIZE_PROD_W-1 -: 16];

	always_comb begin
		if (left_neg_s3) begin
			left_sat = (left_px > 16'd32768) ? 16'h8000 : 16'(~left_px + 16'd1);
		end else begin
			left_sat = (left_px > 16'd32767) ? 16'h7fff : left_px;
		end
		if (top_neg_s3) begin
			top_sat = (top_px > 16'd32768) ? 16'h8000 : 16'(~top_px + 16'd1);
		end else begin
			top_sat = (top_px > 16'd32767) ? 16'h7fff : top_px;
		end
		width_sat = width_px[15] ? 15'h7fff : width_px[14:0];
		height_sat = height_px[15] ? 15'h7fff : height_px[14:0];
	end

	assign out_valid = out_valid_q;
	assign class_index = class_q;
	assign objectness = obj_q;
	assign box_left = left_q;
	assign box_top = top_q;
	assign box_width = width_q;
	assign box_height = height_q;

endmodule

>>> verif/tb_detection_row_decode_filter.sv
// Self-checking testbench for detection_row_decode_filter: tensor beats in, detections out.
// Needs drdf_pkg and the RTL; a directed table runs first, then random rows with register
// changes between phases, checked against a predictor in this file or the table's own detections.
`timescale 1ns / 1ps

module tb_detection_row_decode_filter;

	localparam int ITEMS = 2000;
	localparam int QUIET_LIMIT = 2000;
	localparam int HOLD_CYCLES = 300;

	typedef struct packed {
		logic [7:0] cls;
		logic [19:0] obj;
		logic signed [15:0] left;
		logic signed [15:0] top;
		logic [14:0] width;
		logic [14:0] height;
	} detection_t;

	typedef enum logic {ROW_VALUE, ROW_WRITE} step_op_t;
	typedef enum logic [1:0] {CHK_PREDICT, CHK_NONE, CHK_GIVEN} check_t;

	typedef struct packed {
		step_op_t op;
		drdf_pkg::reg_index_t idx;
		logic [31:0] data;
		check_t chk;
		detection_t want;
	} stim_row_t;

	localparam detection_t NO_DET = '0;

	// Boxes at unit scale, extremes with negative edges, saturation with a tied score,
	// then a row that a class count of zero cuts short in the middle.
	localparam stim_row_t DIRECTED_ROWS [31] = '{
		'{ROW_VALUE, drdf_pkg::REG_CLASS_COUNT, 32'd102400, CHK_PREDICT, NO_DET},
		'{ROW_VALUE, drdf_pkg::REG_CLASS_COUNT, 32'd51200, CHK_PREDICT, NO_DET},
		'{ROW_VALUE, drdf_pkg::REG_CLASS_COUNT, 32'd20480, CHK_PREDICT, NO_DET},
		'{ROW_VALUE, drdf_pkg::REG_CLASS_COUNT, 32'd10240, CHK_PREDICT, NO_DET},
		'{ROW_VALUE, drdf_pkg::REG_CLASS_COUNT, 32'd410, CHK_PREDICT, NO_DET},
		'{ROW_VALUE, drdf_pkg::REG_CLASS_COUNT, 32'd513, CHK_GIVEN,
			'{8'd0, 20'd410, 16'sd90, 16'sd45, 15'd20, 15'd10}},
		'{ROW_VALUE, drdf_pkg::REG_CLASS_COUNT, 32'd0, CHK_PREDICT, NO_DET},
		'{ROW_VALUE, drdf_pkg::REG_CLASS_COUNT, 32'd0, CHK_PREDICT, NO_DET},
		'{ROW_VALUE, drdf_pkg::REG_CLASS_COUNT, 32'hFFFFF, CHK_PREDICT, NO_DET},
		'{ROW_VALUE, drdf_pkg::REG_CLASS_COUNT, 32'hFFFFF, CHK_PREDICT, NO_DET},
		'{ROW_VALUE, drdf_pkg::REG_CLASS_COUNT, 32'hFFFFF, CHK_PREDICT, NO_DET},
		'{ROW_VALUE, drdf_pkg::REG_CLASS_COUNT, 32'hFFFFF, CHK_GIVEN,
			'{8'd0, 20'hFFFFF, -16'sd511, -16'sd511, 15'd1023, 15'd1023}},
		'{ROW_WRITE, drdf_pkg::REG_CLASS_COUNT, 32'd2, CHK_NONE, NO_DET},
		'{ROW_WRITE, drdf_pkg::REG_X_SCALE, 32'd65535, CHK_NONE, NO_DET},
		'{ROW_WRITE, drdf_pkg::REG_Y_SCALE, 32'd0, CHK_NONE, NO_DET},
		'{ROW_VALUE, drdf_pkg::REG_CLASS_COUNT, 32'hFFFFF, CHK_PREDICT, NO_DET},
		'{ROW_VALUE, drdf_pkg::REG_CLASS_COUNT, 32'hFFFFF, CHK_PREDICT, NO_DET},
		'{ROW_VALUE, drdf_pkg::REG_CLASS_COUNT, 32'd0, CHK_PREDICT, NO_DET},
		'{ROW_VALUE, drdf_pkg::REG_CLASS_COUNT, 32'hFFFFF, CHK_PREDICT, NO_DET},
		'{ROW_VALUE, drdf_pkg::REG_CLASS_COUNT, 32'd1024, CHK_PREDICT, NO_DET},
		'{ROW_VALUE, drdf_pkg::REG_CLASS_COUNT, 32'hFFFFF, CHK_PREDICT, NO_DET},
		'{ROW_VALUE, drdf_pkg::REG_CLASS_COUNT, 32'hFFFFF, CHK_GIVEN,
			'{8'd0, 20'd1024, 16'sd32767, 16'sd0, 15'd0, 15'd0}},
		'{ROW_WRITE, drdf_pkg::REG_CLASS_COUNT, 32'd4, CHK_NONE, NO_DET},
		'{ROW_VALUE, drdf_pkg::REG_CLASS_COUNT, 32'd40960, CHK_PREDICT, NO_DET},
		'{ROW_VALUE, drdf_pkg::REG_CLASS_COUNT, 32'd30720, CHK_PREDICT, NO_DET},
		'{ROW_VALUE, drdf_pkg::REG_CLASS_COUNT, 32'd2048, CHK_PREDICT, NO_DET},
		'{ROW_VALUE, drdf_pkg::REG_CLASS_COUNT, 32'd2048, CHK_PREDICT, NO_DET},
		'{ROW_VALUE, drdf_pkg::REG_CLASS_COUNT, 32'd410, CHK_PREDICT, NO_DET},
		'{ROW_VALUE, drdf_pkg::REG_CLASS_COUNT, 32'd512, CHK_PREDICT, NO_DET},
		'{ROW_WRITE, drdf_pkg::REG_CLASS_COUNT, 32'd0, CHK_NONE, NO_DET},
		'{ROW_VALUE, drdf_pkg::REG_CLASS_COUNT, 32'd512, CHK_NONE, NO_DET}
	};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [drdf_pkg::ADDR_W-1:0] paddr = '0;
	logic [drdf_pkg::DATA_W-1:0] pwdata = '0;
	logic [drdf_pkg::DATA_W-1:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [drdf_pkg::VALUE_W-1:0] tensor_value = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [drdf_pkg::CLASS_W-1:0] class_index;
	logic [drdf_pkg::VALUE_W-1:0] objectness;
	logic signed [15:0] box_left;
	logic signed [15:0] box_top;
	logic [14:0] box_width;
	logic [14:0] box_height;

	detection_row_decode_filter dut (.*);

	always #10 clk = ~clk;

	// Predictor state and its copy of the registers.
	logic [8:0] row_pos;
	logic [19:0] box_val [5];
	logic [19:0] top_score;
	logic [7:0] top_class;
	logic [8:0] cfg_classes;
	logic [19:0] cfg_conf;
	logic [19:0] cfg_score;
	logic [15:0] cfg_xs;
	logic [15:0] cfg_ys;

	detection_t detections_due [$];
	int mismatches = 0;
	int accepted_values = 0;
	int quiet_cycles = 0;
	bit draining = 0;
	bit gaps_on = 1;
	bit hold_done = 0;
	bit hold_full = 0;
	int hold_at = HOLD_CYCLES;
	int hold_left = 0;
	int run_left = 0;
	bit stall_level = 0;
	detection_t seen;
	detection_t want;

	function automatic logic signed [15:0] pixel_edge(input logic [19:0] centre,
		input logic [19:0] size, input logic [15:0] scale);
		longint span;
		longint mag;
		span = 2 * longint'(centre) - longint'(size);
		mag = (span < 0) ? -span : span;
		mag = (mag * longint'(scale)) >>> 21;
		if (span < 0) begin
			return (mag > 32768) ? 16'h8000 : 16'(-mag);
		end
		return (mag > 32767) ? 16'h7FFF : 16'(mag);
	endfunction

	function automatic logic [14:0] pixel_size(input logic [19:0] size, input logic [15:0] scale);
		longint prod;
		prod = (longint'(size) * longint'(scale)) >> 20;
		return (prod > 32767) ? 15'h7FFF : 15'(prod);
	endfunction

	function automatic int unsigned active_classes();
		if (cfg_classes == 0) begin
			return 1;
		end
		return (cfg_classes > drdf_pkg::MAX_CLASSES_DEFAULT)
			? drdf_pkg::MAX_CLASSES_DEFAULT : cfg_classes;
	endfunction

	// Advances the row state by one tensor value; returns 1 when a detection leaves.
	function automatic bit decode_value(input logic [19:0] v, output detection_t d);
		int unsigned pos;
		int unsigned last;
		pos = row_pos;
		last = 4 + active_classes();
		d = '0;
		if (pos < 5) begin
			box_val[pos] = v;
		end else if (pos == 5 || v > top_score) begin
			top_score = v;
			top_class = 8'(pos - 5);
		end
		if (pos < last) begin
			row_pos = 9'(pos + 1);
			return 0;
		end
		row_pos = '0;
		if (box_val[4] < cfg_conf || top_score <= cfg_score) begin
			return 0;
		end
		d.cls = top_class;
		d.obj = box_val[4];
		d.left = pixel_edge(box_val[0], box_val[2], cfg_xs);
		d.top = pixel_edge(box_val[1], box_val[3], cfg_ys);
		d.width = pixel_size(box_val[2], cfg_xs);
		d.height = pixel_size(box_val[3], cfg_ys);
		return 1;
	endfunction

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (!gaps_on || r < 65) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return (r < 97) ? $urandom_range(4, 10) : $urandom_range(15, 40);
	endfunction

	function automatic logic [19:0] pick_threshold();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			return '0;
		end
		if (r == 1) begin
			return 20'hFFFFF;
		end
		return (r == 2) ? 20'($urandom) : 20'($urandom_range(0, 2047));
	endfunction

	function automatic logic [15:0] pick_scale();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0) begin
			return '0;
		end
		if (r == 1) begin
			return 16'hFFFF;
		end
		return (r == 2) ? 16'($urandom) : 16'($urandom_range(512, 4096));
	endfunction

	function automatic logic [8:0] pick_class_count();
		int r;
		r = $urandom_range(0, 19);
		case (r)
			0: return '0;
			1: return 9'd256;
			2: return 9'($urandom_range(257, 511));
			3: return 9'($urandom_range(9, 255));
			default: return 9'($urandom_range(1, 8));
		endcase
	endfunction

	// Objectness and scores are steered near their thresholds so both outcomes occur.
	function automatic logic [19:0] pick_value(input bit noisy);
		int r;
		int t;
		r = $urandom_range(0, 99);
		if (noisy || row_pos < 4) begin
			return (r < 50) ? 20'($urandom) : 20'($urandom_range(0, 1 << 17));
		end
		if (row_pos == 4) begin
			t = cfg_conf;
		end else begin
			if (row_pos > 5 && r < 25) begin
				return top_score;
			end
			t = cfg_score;
		end
		if (r < 60) begin
			t = t + int'($urandom_range(0, 8)) - 4;
			if (t < 0) begin
				t = 0;
			end
			if (t > 20'hFFFFF) begin
				t = 20'hFFFFF;
			end
			return 20'(t);
		end
		return (r < 85) ? 20'($urandom_range(0, 4095)) : 20'($urandom);
	endfunction

	task automatic expect_detection(input detection_t d);
		detections_due = {detections_due, d};
	endtask

	task automatic offer_value(input logic [19:0] v);
		int gap;
		gap = gap_len();
		@(negedge clk);
		if (gap != 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		tensor_value = v;
		do @(posedge clk); while (in_stall !== 1'b0);
		accepted_values++;
	endtask

	task automatic feed(input logic [19:0] v);
		detection_t d;
		offer_value(v);
		if (decode_value(v, d)) begin
			expect_detection(d);
		end
	endtask

	task automatic write_reg(input drdf_pkg::reg_index_t idx, input logic [31:0] val);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		case (idx)
			drdf_pkg::REG_CLASS_COUNT: cfg_classes = val[8:0];
			drdf_pkg::REG_CONF_THRESH: cfg_conf = val[19:0];
			drdf_pkg::REG_SCORE_THRESH: cfg_score = val[19:0];
			drdf_pkg::REG_X_SCALE: cfg_xs = val[15:0];
			drdf_pkg::REG_Y_SCALE: cfg_ys = val[15:0];
			default: ;
		endcase
	endtask

	// The pipeline holds on an output stall, so the settle count only runs while unstalled.
	task automatic wait_idle();
		int n;
		@(negedge clk);
		in_valid = 1'b0;
		draining = 1;
		while (detections_due.size() != 0) @(posedge clk);
		n = 0;
		while (n < 8) begin
			@(posedge clk);
			n = (out_stall === 1'b0) ? n + 1 : 0;
		end
		draining = 0;
	endtask

	// The long hold is repeated later in the run until it has seen the input stalled.
	always @(negedge clk) begin
		if (!hold_done && hold_left == 0 && in_valid && accepted_values >= hold_at) begin
			hold_left = HOLD_CYCLES;
			hold_full = 0;
		end
		if (hold_left != 0) begin
			if (in_stall === 1'b1) begin
				hold_full = 1;
			end
			hold_left--;
			if (hold_left == 0) begin
				hold_done = hold_full;
				hold_at = accepted_values + HOLD_CYCLES;
			end
			out_stall = 1'b1;
		end else if (draining) begin
			run_left = 0;
			out_stall = 1'b0;
		end else begin
			if (run_left == 0) begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: begin
						stall_level = 0;
						run_left = $urandom_range(1, 8);
					end
					5, 6: begin
						stall_level = 0;
						run_left = $urandom_range(20, 60);
					end
					9: begin
						stall_level = 1;
						run_left = $urandom_range(10, 40);
					end
					default: begin
						stall_level = 1;
						run_left = $urandom_range(1, 3);
					end
				endcase
			end
			run_left--;
			out_stall = stall_level;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			seen = '{class_index, objectness, box_left, box_top, box_width, box_height};
			if (detections_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected detection: cls=%0d obj=%0d left=%0d top=%0d w=%0d h=%0d",
						seen.cls, seen.obj, seen.left, seen.top, seen.width, seen.height);
				end
			end else begin
				want = detections_due.pop_front();
				if (seen !== want) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("detection mismatch: expected cls=%0d obj=%0d left=%0d top=%0d w=%0d h=%0d",
							want.cls, want.obj, want.left, want.top, want.width, want.height);
						$display("                    actual   cls=%0d obj=%0d left=%0d top=%0d w=%0d h=%0d",
							seen.cls, seen.obj, seen.left, seen.top, seen.width, seen.height);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
		end
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		stim_row_t row;
		detection_t d;
		bit hit;
		int rows;
		int phase;
		row_pos = '0;
		foreach (box_val[i]) begin
			box_val[i] = '0;
		end
		top_score = '0;
		top_class = '0;
		cfg_classes = drdf_pkg::CLASS_COUNT_RESET;
		cfg_conf = drdf_pkg::CONF_THRESH_RESET;
		cfg_score = drdf_pkg::SCORE_THRESH_RESET;
		cfg_xs = drdf_pkg::X_SCALE_RESET;
		cfg_ys = drdf_pkg::Y_SCALE_RESET;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (DIRECTED_ROWS[i]) begin
			row = DIRECTED_ROWS[i];
			if (row.op == ROW_WRITE) begin
				wait_idle();
				write_reg(row.idx, row.data);
			end else if (row.chk == CHK_PREDICT) begin
				feed(row.data[19:0]);
			end else begin
				offer_value(row.data[19:0]);
				hit = decode_value(row.data[19:0], d);
				if (row.chk == CHK_GIVEN) begin
					expect_detection(row.want);
				end
			end
		end

		// Each phase ends at an idle point; a partial row left behind meets the new
		// class count on the next phase.
		phase = 0;
		while (accepted_values < ITEMS && phase < 400) begin
			wait_idle();
			if (phase == 0 || $urandom_range(0, 2) != 0) begin
				write_reg(drdf_pkg::REG_CLASS_COUNT, 32'(pick_class_count()));
			end
			if (phase == 0 || $urandom_range(0, 1) != 0) begin
				write_reg(drdf_pkg::REG_CONF_THRESH, 32'(pick_threshold()));
			end
			if (phase == 0 || $urandom_range(0, 1) != 0) begin
				write_reg(drdf_pkg::REG_SCORE_THRESH, 32'(pick_threshold()));
			end
			if (phase == 0 || $urandom_range(0, 1) != 0) begin
				write_reg(drdf_pkg::REG_X_SCALE, 32'(pick_scale()));
			end
			if (phase == 0 || $urandom_range(0, 1) != 0) begin
				write_reg(drdf_pkg::REG_Y_SCALE, 32'(pick_scale()));
			end
			gaps_on = ($urandom_range(0, 3) != 0);
			rows = (active_classes() > 16) ? $urandom_range(1, 2) : $urandom_range(3, 30);
			repeat (rows) begin
				hit = ($urandom_range(0, 9) == 0);
				do feed(pick_value(hit)); while (row_pos != 0);
			end
			if ($urandom_range(0, 3) == 0) begin
				repeat ($urandom_range(1, 8)) feed(pick_value(0));
			end
			phase++;
		end

		wait_idle();
		if (mismatches == 0 && detections_due.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

>>> files.f
sv/drdf_pkg.sv
sv/drdf_box_scale.sv
sv/detection_row_decode_filter.sv
verif/tb_detection_row_decode_filter.sv
